>>> hw/rtl/fhsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhsp_pkg
// Shared types and constants of the frame header sync parser.
// ----------------------------------------------------------------------------
package fhsp_pkg;

   // Frame word and header geometry
   localparam logic [15:0] FRAME_WORD      = 16'h9c9c;
   localparam int          HEADER_LEN      = 16;
   localparam int          HDR_STORE       = HEADER_LEN - 2;
   localparam int          HDR_SHIFT       = HDR_STORE - 1;
   localparam logic [31:0] WEEK_HUNDREDTHS = 32'd60480000;

   // Hunt limit in byte pairs and width of the pair counter
   localparam int          HUNT_CNT_W      = 11;
   localparam logic [HUNT_CNT_W-1:0] MAX_HUNT_PAIRS = 11'd1024;

   // Reset values of the sanity limits
   localparam logic [15:0] MAX_WEEK_RST    = 16'd5000;
   localparam logic [15:0] MAX_LENGTH_RST  = 16'd1024;
   localparam logic [15:0] MAX_ID_RST      = 16'd1024;

   // Register indexes on the configuration port
   localparam logic [1:0]  CSR_MAX_WEEK    = 2'd0;
   localparam logic [1:0]  CSR_MAX_LENGTH  = 2'd1;
   localparam logic [1:0]  CSR_MAX_ID      = 2'd2;

   typedef enum logic [1:0] {
      MODE_HUNT   = 2'd0,
      MODE_HEADER = 2'd1,
      MODE_BODY   = 2'd2
   } parse_mode_type;

   typedef enum logic [1:0] {
      KIND_GOOD   = 2'd0,
      KIND_INSANE = 2'd1,
      KIND_HUNT   = 2'd2,
      KIND_BODY   = 2'd3
   } kind_type;

   // Sanity limits as written over the configuration port
   typedef struct packed {
      logic [15:0] max_week;
      logic [15:0] max_length;
      logic [15:0] max_id;
   } limits_type;

   // Decoded header, with fields already in the form they are reported
   typedef struct packed {
      logic        insane;
      logic        has_body;
      logic [15:0] body_count;
      logic [15:0] msg_id;
      logic [15:0] msg_length;
      logic [15:0] week_number;
      logic [31:0] week_hundredths;
      logic [15:0] freshness;
      logic [15:0] crc_word;
   } hdr_info_type;

endpackage

>>> hw/rtl/fhsp_hdr_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhsp_hdr_decode
// Splits the collected header bytes into fields, checks them for sanity and
// applies the full-week rollover.
// ----------------------------------------------------------------------------
module fhsp_hdr_decode (
   input  logic [fhsp_pkg::HDR_STORE-1:0][7:0] hdr_bytes,
   input  fhsp_pkg::limits_type                limits,
   output fhsp_pkg::hdr_info_type              info
);

   logic [15:0] id;
   logic [15:0] len;
   logic [15:0] week;
   logic [31:0] hund;
   logic        insane;
   logic        full_week;

   // Big-endian field extraction
   assign id   = {hdr_bytes[0], hdr_bytes[1]};
   assign len  = {hdr_bytes[2], hdr_bytes[3]};
   assign week = {hdr_bytes[4], hdr_bytes[5]};
   assign hund = {hdr_bytes[6], hdr_bytes[7], hdr_bytes[8], hdr_bytes[9]};

   // Sanity check against the programmed limits
   assign insane = (hund > fhsp_pkg::WEEK_HUNDREDTHS) || (week > limits.max_week) ||
                   (len > limits.max_length) || (id > limits.max_id);
   assign full_week = (hund == fhsp_pkg::WEEK_HUNDREDTHS);

   always_comb begin
      info.insane     = insane;
      info.msg_id     = id;
      info.freshness  = {hdr_bytes[10], hdr_bytes[11]};
      info.crc_word   = {hdr_bytes[12], hdr_bytes[13]};
      info.has_body   = !insane && (len > 16'(fhsp_pkg::HEADER_LEN));
      info.body_count = len - 16'(fhsp_pkg::HEADER_LEN);
      if (insane) begin
         // An insane header reports a zero length and its raw time fields.
         info.msg_length      = '0;
         info.week_number     = week;
         info.week_hundredths = hund;
      end else if (full_week) begin
         // A full week of hundredths rolls into the next week.
         info.msg_length      = len;
         info.week_number     = week + 16'd1;
         info.week_hundredths = '0;
      end else begin
         info.msg_length      = len;
         info.week_number     = week;
         info.week_hundredths = hund;
      end
   end

endmodule

>>> hw/rtl/frame_header_sync_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_header_sync_parser
// Frame word hunter, header decoder and body byte forwarder.
// ----------------------------------------------------------------------------
// Usage: bytes of the received stream enter one byte per handshake on the
// req_ channel (valid/ready). The block hunts for the frame word 0x9c9c in
// aligned byte pairs, collects the rest of the 16-byte header, and returns
// one rsp_ word for a decoded header (good or insane), for an exhausted hunt
// and for every body byte, the final one marked by rsp_body_last. Bytes that
// cause no result (hunt pairs, header bytes) are consumed silently.
// Throughput is one byte per cycle while the receiver keeps up: each byte
// is held in an input register and processed from there into the result
// register, which drives rsp_valid. The pace is set by the single parse
// step between those two registers.
// When the receiver stalls, the result register holds its word and the input
// register keeps one more byte, after which req_ready falls. The csr_ port
// writes the sanity limits (week, length, id); the user writes them only while
// idle, which the block itself does not enforce. A synchronous reset restores
// the default limits and restarts the hunt with empty input and result registers.
// ----------------------------------------------------------------------------
module frame_header_sync_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_msg_id,
   output logic [15:0] rsp_msg_length,
   output logic [15:0] rsp_week_number,
   output logic [31:0] rsp_week_hundredths,
   output logic [15:0] rsp_freshness,
   output logic [15:0] rsp_crc_word,
   output logic [7:0]  rsp_body_byte,
   output logic        rsp_body_last,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int HS = fhsp_pkg::HDR_SHIFT;

   fhsp_pkg::limits_type     limits_ff;
   fhsp_pkg::parse_mode_type mode_ff, mode_in;
   logic                     phase_ff, phase_in;
   logic [7:0]               held_ff, held_in;
   logic [fhsp_pkg::HUNT_CNT_W-1:0] hunt_ff, hunt_in;
   logic [15:0]              cnt_ff, cnt_in;
   logic [HS-1:0][7:0]       hdr_ff, hdr_in;

   logic                     in_valid_ff;
   logic [7:0]               in_byte_ff;
   logic                     step;

   logic                     rsp_valid_ff;
   fhsp_pkg::kind_type       kind_ff, kind_in;
   logic [15:0]              id_ff, id_in, len_ff, len_in, week_ff, week_in;
   logic [31:0]              hund_ff, hund_in;
   logic [15:0]              fresh_ff, fresh_in, crc_ff, crc_in;
   logic [7:0]               body_ff, body_in;
   logic                     last_ff, last_in;
   logic                     emit;

   logic [fhsp_pkg::HDR_STORE-1:0][7:0] hdr_full;
   fhsp_pkg::hdr_info_type   info;
   logic [fhsp_pkg::HUNT_CNT_W-1:0] hunt_inc;

   // Handshake: the byte in the input register is processed when the result
   // register is free or being emptied this cycle.
   assign step      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.max_week   <= fhsp_pkg::MAX_WEEK_RST;
         limits_ff.max_length <= fhsp_pkg::MAX_LENGTH_RST;
         limits_ff.max_id     <= fhsp_pkg::MAX_ID_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            fhsp_pkg::CSR_MAX_WEEK:   limits_ff.max_week   <= csr_wdata;
            fhsp_pkg::CSR_MAX_LENGTH: limits_ff.max_length <= csr_wdata;
            fhsp_pkg::CSR_MAX_ID:     limits_ff.max_id     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   // The final header byte is taken straight from the input register.
   assign hdr_full = {in_byte_ff, hdr_ff};

   fhsp_hdr_decode u_hdr_decode (
      .hdr_bytes (hdr_full),
      .limits    (limits_ff),
      .info      (info)
   );

   assign hunt_inc = hunt_ff + 1'b1;

   // Parse step: next state and the result word of the current byte
   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      hunt_in  = hunt_ff;
      cnt_in   = cnt_ff;
      hdr_in   = hdr_ff;
      emit     = 1'b0;
      kind_in  = fhsp_pkg::KIND_GOOD;
      id_in    = '0;
      len_in   = '0;
      week_in  = '0;
      hund_in  = '0;
      fresh_in = '0;
      crc_in   = '0;
      body_in  = '0;
      last_in  = 1'b0;

      case (mode_ff)
         fhsp_pkg::MODE_HEADER: begin
            hdr_in = {in_byte_ff, hdr_ff[HS-1:1]};
            cnt_in = cnt_ff + 16'd1;
            if (cnt_ff == 16'(HS)) begin
               // Header complete: report it and leave for body or hunt.
               emit     = 1'b1;
               kind_in  = info.insane ? fhsp_pkg::KIND_INSANE : fhsp_pkg::KIND_GOOD;
               id_in    = info.msg_id;
               len_in   = info.msg_length;
               week_in  = info.week_number;
               hund_in  = info.week_hundredths;
               fresh_in = info.freshness;
               crc_in   = info.crc_word;
               phase_in = 1'b0;
               held_in  = '0;
               hunt_in  = '0;
               if (info.has_body) begin
                  mode_in = fhsp_pkg::MODE_BODY;
                  cnt_in  = info.body_count;
               end else begin
                  mode_in = fhsp_pkg::MODE_HUNT;
                  cnt_in  = '0;
               end
            end
         end
         fhsp_pkg::MODE_BODY: begin
            emit    = 1'b1;
            kind_in = fhsp_pkg::KIND_BODY;
            body_in = in_byte_ff;
            if (cnt_ff <= 16'd1) begin
               last_in = 1'b1;
               mode_in = fhsp_pkg::MODE_HUNT;
               cnt_in  = '0;
            end else begin
               cnt_in = cnt_ff - 16'd1;
            end
         end
         default: begin
            // Hunting: pair bytes high first and look for the frame word.
            mode_in = fhsp_pkg::MODE_HUNT;
            if (!phase_ff) begin
               held_in  = in_byte_ff;
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if ({held_ff, in_byte_ff} == fhsp_pkg::FRAME_WORD) begin
                  mode_in = fhsp_pkg::MODE_HEADER;
                  cnt_in  = '0;
                  hunt_in = '0;
               end else if (hunt_inc >= fhsp_pkg::MAX_HUNT_PAIRS) begin
                  hunt_in = '0;
                  emit    = 1'b1;
                  kind_in = fhsp_pkg::KIND_HUNT;
               end else begin
                  hunt_in = hunt_inc;
               end
            end
         end
      endcase
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= fhsp_pkg::MODE_HUNT;
         phase_ff <= 1'b0;
         held_ff  <= '0;
         hunt_ff  <= '0;
         cnt_ff   <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
         hunt_ff  <= hunt_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         hdr_ff <= hdr_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         kind_ff  <= kind_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         week_ff  <= week_in;
         hund_ff  <= hund_in;
         fresh_ff <= fresh_in;
         crc_ff   <= crc_in;
         body_ff  <= body_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_msg_id          = id_ff;
   assign rsp_msg_length      = len_ff;
   assign rsp_week_number     = week_ff;
   assign rsp_week_hundredths = hund_ff;
   assign rsp_freshness       = fresh_ff;
   assign rsp_crc_word        = crc_ff;
   assign rsp_body_byte       = body_ff;
   assign rsp_body_last       = last_ff;

endmodule
